// File: rtl/dlpw_pkg.sv
// Shared types and constants for the DDA line pixel walker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dlpw_pkg;

    localparam int COORD_W = 12;
    localparam int DELTA_W = 13;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 24;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;
    localparam logic signed [DELTA_W-1:0] SCREEN_W_LIM = DELTA_W'(SCREEN_WIDTH);
    localparam logic signed [DELTA_W-1:0] SCREEN_H_LIM = DELTA_W'(SCREEN_HEIGHT);

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Configuration register indexes and reset values.
    localparam int CFG_DATA_W = 14;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_STRIDE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BITS_PER_PIXEL = 1'b1;
    localparam logic [13:0] STRIDE_RESET = 14'd4096;
    localparam logic [5:0]  BPP_RESET    = 6'd32;

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        line_color;
    } in_item_t;

    typedef struct packed {
        logic                      has_pixel;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]         byte_address;
        logic                      visible;
        logic [COLOR_W-1:0]        pixel_color;
        logic                      last;
    } out_item_t;

    // A classified command: a step, or a load already set up along its major axis.
    typedef struct packed {
        logic                      is_load;
        logic                      major_is_x;
        logic                      maj_neg;
        logic signed [COORD_W-1:0] maj_start;
        logic signed [COORD_W-1:0] min_start;
        logic signed [DELTA_W-1:0] d_minor;
        logic [COORD_W-1:0]        adm;
        logic [COLOR_W-1:0]        color;
    } line_cmd_t;

endpackage

`default_nettype wire

// File: rtl/dda_line_pixel_walker.sv
// DDA line pixel walker, top level. Uses dlpw_pkg, dlpw_front, dlpw_queue, dlpw_back.
// A step beat passes the queue, the coordinate stage, the multiply stage and the output
// register before it shows on the output; loads give no output.
// Throughput: one beat per cycle while the output does not stall, with a two-entry
// command queue between front and back; output stall backs up through the stages and the queue.
// Reset (rst_n low, asynchronous): queue and stages empty, stride 4096, 32 bits per pixel, no line.
`default_nettype none

module dda_line_pixel_walker
    import dlpw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      q_full;
    logic      push;
    line_cmd_t push_cmd;
    logic      q_valid;
    logic      pop;
    line_cmd_t head_cmd;

    dlpw_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    dlpw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .head_cmd (head_cmd)
    );

    dlpw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// File: rtl/dlpw_front.sv
// Front part: accepts input beats and classifies them into queue commands.
// Loads are set up here (deltas, major axis, magnitude). Uses dlpw_pkg.
`default_nettype none

module dlpw_front
    import dlpw_pkg::*;
(
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    input  wire logic      q_full,
    output logic           push,
    output line_cmd_t      cmd
);

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [COORD_W-1:0]        adx;
    logic [COORD_W-1:0]        ady;
    logic                      major_x;

    always_comb
    begin
        dx = {in_item.end_x[COORD_W-1], in_item.end_x}
             - {in_item.start_x[COORD_W-1], in_item.start_x};
        dy = {in_item.end_y[COORD_W-1], in_item.end_y}
             - {in_item.start_y[COORD_W-1], in_item.start_y};
        adx = dx[DELTA_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ady = dy[DELTA_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
        major_x = (adx >= ady);

        cmd.is_load    = (in_item.req_type == REQ_LOAD);
        cmd.major_is_x = major_x;
        cmd.maj_neg    = major_x ? dx[DELTA_W-1] : dy[DELTA_W-1];
        cmd.maj_start  = major_x ? in_item.start_x : in_item.start_y;
        cmd.min_start  = major_x ? in_item.start_y : in_item.start_x;
        cmd.d_minor    = major_x ? dy : dx;
        cmd.adm        = major_x ? adx : ady;
        cmd.color      = in_item.line_color;
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

// File: rtl/dlpw_queue.sv
// Short command queue that decouples the front from the back.
// Holds QDEPTH classified commands. Uses dlpw_pkg.
`default_nettype none

module dlpw_queue
    import dlpw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire line_cmd_t  push_cmd,
    output logic            full,
    output logic            q_valid,
    input  wire logic       pop,
    output line_cmd_t       head_cmd
);

    line_cmd_t         entry [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = entry[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/dlpw_back.sv
// Back part: holds the line, walks it one pixel per step command and forms
// the byte address over a coordinate, a multiply and an output stage. Uses dlpw_pkg.
`default_nettype none

module dlpw_back
    import dlpw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  q_valid,
    input  wire line_cmd_t             q_cmd,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item
);

    // Configuration.
    logic [13:0] stride_reg;
    logic [13:0] stride_next;
    logic [5:0]  bpp_reg;
    logic [5:0]  bpp_next;

    // Line walker. The minor coordinate is kept as floor(num / adm) plus a
    // remainder in [0, adm), where num = min_start*adm + d_minor*k.
    logic                      major_x_reg,   major_x_next;
    logic                      maj_neg_reg,   maj_neg_next;
    logic signed [COORD_W-1:0] maj_start_reg, maj_start_next;
    logic signed [DELTA_W-1:0] d_minor_reg,   d_minor_next;
    logic [COORD_W-1:0]        adm_reg,       adm_next;
    logic [DELTA_W-1:0]        k_reg,         k_next;
    logic signed [DELTA_W-1:0] q_reg,         q_next;
    logic [COORD_W-1:0]        rem_reg,       rem_next;
    logic [COLOR_W-1:0]        color_reg,     color_next;

    // Pipeline valids and handshakes.
    logic c_vld_reg, c_vld_next;
    logic m_vld_reg, m_vld_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, m_adv, m_free, c_adv, c_free, step_pop;

    // Coordinate stage.
    logic                      c_hit_reg;
    logic signed [COORD_W-1:0] c_px_reg;
    logic signed [COORD_W-1:0] c_py_reg;
    logic                      c_last_reg;
    logic [COLOR_W-1:0]        c_color_reg;

    // Multiply stage.
    logic                      m_hit_reg;
    logic signed [COORD_W-1:0] m_px_reg;
    logic signed [COORD_W-1:0] m_py_reg;
    logic                      m_last_reg;
    logic [COLOR_W-1:0]        m_color_reg;
    logic signed [26:0]        prod_y_reg, prod_y_next;
    logic signed [18:0]        prod_x_reg, prod_x_next;

    out_item_t out_item_reg, out_item_next;

    // Step arithmetic.
    logic                      hit;
    logic [DELTA_W-1:0]        k_inc;
    logic signed [DELTA_W-1:0] pmaj;
    logic signed [DELTA_W-1:0] pmin;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [13:0]        rem_sum;
    logic signed [13:0]        adm_ext;

    // Address arithmetic.
    logic signed [18:0]        prod_x_adj;
    logic signed [18:0]        x_bytes;
    logic signed [27:0]        addr;
    logic signed [DELTA_W-1:0] m_px_ext;
    logic signed [DELTA_W-1:0] m_py_ext;
    logic                      vis;

    assign out_free = !out_valid_reg || !out_stall;
    assign m_adv    = m_vld_reg && out_free;
    assign m_free   = !m_vld_reg || m_adv;
    assign c_adv    = c_vld_reg && m_free;
    assign c_free   = !c_vld_reg || c_adv;
    assign pop      = q_valid && (q_cmd.is_load || c_free);
    assign step_pop = pop && !q_cmd.is_load;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        stride_next = stride_reg;
        bpp_next    = bpp_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LINE_STRIDE:    stride_next = cfg_wdata;
                REG_BITS_PER_PIXEL: bpp_next    = cfg_wdata[5:0];
                default:            stride_next = stride_reg;
            endcase
        end
    end

    always_comb
    begin
        hit     = (k_reg < {1'b0, adm_reg});
        k_inc   = k_reg + 1'b1;
        pmaj    = maj_neg_reg ? {maj_start_reg[COORD_W-1], maj_start_reg} - k_reg
                              : {maj_start_reg[COORD_W-1], maj_start_reg} + k_reg;
        // Floor to truncation: a negative quotient with a remainder rounds up.
        pmin    = q_reg + ((q_reg[DELTA_W-1] && rem_reg != '0) ? 13'sd1 : 13'sd0);
        px      = major_x_reg ? pmaj[COORD_W-1:0] : pmin[COORD_W-1:0];
        py      = major_x_reg ? pmin[COORD_W-1:0] : pmaj[COORD_W-1:0];
        rem_sum = $signed({2'b00, rem_reg}) + $signed({d_minor_reg[DELTA_W-1], d_minor_reg});
        adm_ext = $signed({2'b00, adm_reg});

        major_x_next   = major_x_reg;
        maj_neg_next   = maj_neg_reg;
        maj_start_next = maj_start_reg;
        d_minor_next   = d_minor_reg;
        adm_next       = adm_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        color_next     = color_reg;

        if (pop && q_cmd.is_load)
        begin
            major_x_next   = q_cmd.major_is_x;
            maj_neg_next   = q_cmd.maj_neg;
            maj_start_next = q_cmd.maj_start;
            d_minor_next   = q_cmd.d_minor;
            adm_next       = q_cmd.adm;
            k_next         = '0;
            q_next         = {q_cmd.min_start[COORD_W-1], q_cmd.min_start};
            rem_next       = '0;
            color_next     = q_cmd.color;
        end
        else if (step_pop && hit)
        begin
            k_next = k_inc;
            // |d_minor| <= adm, so one correction step keeps the remainder in range.
            if (rem_sum >= adm_ext)
            begin
                q_next   = q_reg + 13'sd1;
                rem_next = COORD_W'(rem_sum - adm_ext);
            end
            else if (rem_sum < 14'sd0)
            begin
                q_next   = q_reg - 13'sd1;
                rem_next = COORD_W'(rem_sum + adm_ext);
            end
            else
            begin
                rem_next = rem_sum[COORD_W-1:0];
            end
        end
    end

    always_comb
    begin
        c_vld_next     = step_pop ? 1'b1 : (c_adv ? 1'b0 : c_vld_reg);
        m_vld_next     = c_adv ? 1'b1 : (m_adv ? 1'b0 : m_vld_reg);
        out_valid_next = m_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        prod_y_next = 27'($signed({1'b0, stride_reg})) * 27'(c_py_reg);
        prod_x_next = 19'($signed({1'b0, bpp_reg})) * 19'(c_px_reg);
    end

    always_comb
    begin
        // Division by 8 rounds toward zero.
        prod_x_adj = prod_x_reg + (prod_x_reg[18] ? 19'sd7 : 19'sd0);
        x_bytes    = prod_x_adj >>> 3;
        addr       = {prod_y_reg[26], prod_y_reg} + {{9{x_bytes[18]}}, x_bytes};
        m_px_ext   = {m_px_reg[COORD_W-1], m_px_reg};
        m_py_ext   = {m_py_reg[COORD_W-1], m_py_reg};
        vis        = (addr[27:24] == 4'b0000) && (m_px_ext < SCREEN_W_LIM)
                     && (m_py_ext < SCREEN_H_LIM);

        out_item_next = '0;
        if (m_hit_reg)
        begin
            out_item_next.has_pixel    = 1'b1;
            out_item_next.pixel_x      = m_px_reg;
            out_item_next.pixel_y      = m_py_reg;
            out_item_next.byte_address = vis ? addr[ADDR_W-1:0] : '0;
            out_item_next.visible      = vis;
            out_item_next.pixel_color  = m_color_reg;
            out_item_next.last         = m_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= STRIDE_RESET;
            bpp_reg       <= BPP_RESET;
            major_x_reg   <= 1'b1;
            maj_neg_reg   <= 1'b0;
            maj_start_reg <= '0;
            d_minor_reg   <= '0;
            adm_reg       <= '0;
            k_reg         <= '0;
            q_reg         <= '0;
            rem_reg       <= '0;
            color_reg     <= '0;
            c_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stride_reg    <= stride_next;
            bpp_reg       <= bpp_next;
            major_x_reg   <= major_x_next;
            maj_neg_reg   <= maj_neg_next;
            maj_start_reg <= maj_start_next;
            d_minor_reg   <= d_minor_next;
            adm_reg       <= adm_next;
            k_reg         <= k_next;
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            color_reg     <= color_next;
            c_vld_reg     <= c_vld_next;
            m_vld_reg     <= m_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_pop)
        begin
            c_hit_reg   <= hit;
            c_px_reg    <= px;
            c_py_reg    <= py;
            c_last_reg  <= (k_inc == {1'b0, adm_reg});
            c_color_reg <= color_reg;
        end
        if (c_adv)
        begin
            m_hit_reg   <= c_hit_reg;
            m_px_reg    <= c_px_reg;
            m_py_reg    <= c_py_reg;
            m_last_reg  <= c_last_reg;
            m_color_reg <= c_color_reg;
            prod_y_reg  <= prod_y_next;
            prod_x_reg  <= prod_x_next;
        end
        if (m_adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= {1'b0, adm_reg})
        else $error("step index ran past the line length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) || (rem_reg < adm_reg))
        else $error("minor remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.has_pixel |->
            out_item_reg.byte_address == '0 && !out_item_reg.visible
            && !out_item_reg.last && out_item_reg.pixel_color == '0)
        else $error("finished-line beat carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && !m_free |=> c_vld_reg && $stable(c_px_reg) && $stable(c_py_reg))
        else $error("coordinate stage lost a pixel while blocked");

endmodule

`default_nettype wire

// File: sim/tb_dda_line_pixel_walker.sv
// Self-checking testbench for dda_line_pixel_walker: drives load and step beats and
// register writes, predicts every pixel beat and compares it field by field.
// Depends on rtl/dlpw_pkg.sv and rtl/dda_line_pixel_walker.sv.

module tb_dda_line_pixel_walker;
    import dlpw_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int BEATS_PER_PHASE = 75;
    localparam int NUM_PHASES = 6;

    // Pixel predictor and scoreboard for the line walker.
    class line_walk_scoreboard;
        out_item_t pending_pixels[$];
        int unsigned stride;
        int unsigned bpp;
        int org_x;
        int org_y;
        int dx;
        int dy;
        int walk_k;
        bit major_x;
        logic [COLOR_W-1:0] color;
        int unsigned mismatches;
        int unsigned pixels_checked;
        int unsigned pixels_drawn;
        int unsigned pixels_visible;
        int unsigned finished_replies;

        function new();
            stride = 4096;
            bpp = 32;
            org_x = 0;
            org_y = 0;
            dx = 0;
            dy = 0;
            walk_k = 0;
            major_x = 1'b1;
            color = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_LINE_STRIDE)
                stride = data;
            else
                bpp = data[5:0];
        endfunction

        function void note_beat(in_item_t beat);
            int dmaj;
            int dmin;
            int smaj;
            int smin;
            int adm;
            int pmaj;
            int pmin;
            int px;
            int py;
            longint num;
            longint addr;
            bit vis;
            out_item_t want;
            if (beat.req_type == REQ_LOAD) begin
                org_x = beat.start_x;
                org_y = beat.start_y;
                dx = int'(beat.end_x) - org_x;
                dy = int'(beat.end_y) - org_y;
                major_x = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy);
                walk_k = 0;
                color = beat.line_color;
                return;
            end
            want = '0;
            dmaj = major_x ? dx : dy;
            dmin = major_x ? dy : dx;
            smaj = major_x ? org_x : org_y;
            smin = major_x ? org_y : org_x;
            adm = (dmaj < 0) ? -dmaj : dmaj;
            if (walk_k < adm) begin
                pmaj = (dmaj < 0) ? smaj - walk_k : smaj + walk_k;
                // Exact rational position on the minor axis, truncated toward zero.
                num = longint'(smin) * adm + longint'(dmin) * walk_k;
                pmin = int'(num / longint'(adm));
                px = major_x ? pmaj : pmin;
                py = major_x ? pmin : pmaj;
                addr = longint'(stride) * py + (longint'(bpp) * px) / 8;
                vis = addr >= 0 && addr <= 64'hFF_FFFF && px < SCREEN_WIDTH
                      && py < SCREEN_HEIGHT;
                walk_k++;
                want.has_pixel = 1'b1;
                want.pixel_x = px[COORD_W-1:0];
                want.pixel_y = py[COORD_W-1:0];
                want.byte_address = vis ? addr[ADDR_W-1:0] : '0;
                want.visible = vis;
                want.pixel_color = color;
                want.last = (walk_k == adm);
            end
            pending_pixels.push_back(want);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return;
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s in pixel beat %0d: expected %h, got %h",
                         name, pixels_checked, want, got);
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pixel beat: %h", got);
                return;
            end
            want = pending_pixels.pop_front();
            check_field("has_pixel", want.has_pixel, got.has_pixel);
            check_field("pixel_x", want.pixel_x, got.pixel_x);
            check_field("pixel_y", want.pixel_y, got.pixel_y);
            check_field("byte_address", want.byte_address, got.byte_address);
            check_field("visible", want.visible, got.visible);
            check_field("pixel_color", want.pixel_color, got.pixel_color);
            check_field("last", want.last, got.last);
            pixels_checked++;
            if (want.has_pixel)
                pixels_drawn++;
            else
                finished_replies++;
            if (want.visible)
                pixels_visible++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    line_walk_scoreboard sb;
    int unsigned cycle_count;
    int unsigned beats_sent;
    int unsigned reg_writes;
    int unsigned idle_pct;
    int unsigned stall_pct;

    dda_line_pixel_walker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    // Receiver: random back-pressure on the result channel.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(out_item);
    end

    task automatic send_beat(input in_item_t beat);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= beat;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(beat);
        beats_sent++;
    endtask

    task automatic send_step();
        in_item_t beat;
        beat.req_type = REQ_STEP;
        beat.start_x = COORD_W'($urandom);
        beat.start_y = COORD_W'($urandom);
        beat.end_x = COORD_W'($urandom);
        beat.end_y = COORD_W'($urandom);
        beat.line_color = COLOR_W'($urandom);
        send_beat(beat);
    endtask

    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [COLOR_W-1:0] c, input int n_steps);
        in_item_t beat;
        beat.req_type = REQ_LOAD;
        beat.start_x = sx[COORD_W-1:0];
        beat.start_y = sy[COORD_W-1:0];
        beat.end_x = ex[COORD_W-1:0];
        beat.end_y = ey[COORD_W-1:0];
        beat.line_color = c;
        send_beat(beat);
        repeat (n_steps)
            send_step();
    endtask

    function automatic int clamp_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // Mostly short lines near the screen; short ones run to the end or a bit past.
    task automatic random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int n;
        if ($urandom_range(99) < 70) begin
            sx = int'($urandom_range(1164)) - 64;
            sy = int'($urandom_range(1164)) - 64;
        end else begin
            sx = int'($urandom_range(4095)) - 2048;
            sy = int'($urandom_range(4095)) - 2048;
        end
        if ($urandom_range(99) < 3) begin
            ex = sx;
            ey = sy;
        end else if ($urandom_range(99) < 85) begin
            ex = clamp_coord(sx + int'($urandom_range(48)) - 24);
            ey = clamp_coord(sy + int'($urandom_range(48)) - 24);
        end else begin
            ex = int'($urandom_range(4095)) - 2048;
            ey = int'($urandom_range(4095)) - 2048;
        end
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span)
            span = (ey > sy) ? ey - sy : sy - ey;
        n = span + int'($urandom_range(3));
        if (n > 40)
            n = int'($urandom_range(40, 1));
        send_line(sx, sy, ex, ey, COLOR_W'($urandom), n);
    endtask

    // Lowers valid and waits until every expected pixel beat has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned target;
        int unsigned r;
        sb = new();
        cycle_count = 0;
        beats_sent = 0;
        reg_writes = 0;
        idle_pct = 18;
        stall_pct = 18;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_LINE_STRIDE;
        cfg_wdata = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed: step with no line loaded, a zero-length line, the extreme
        // corners, negative directions on both axes, negative x still visible,
        // and a line below the screen.
        send_step();
        send_line(5, 5, 5, 5, 24'h123456, 1);
        send_line(-2048, 2047, 2047, -2048, 24'hFF_FFFF, 2);
        send_line(10, 3, 7, 1, 24'h00_0000, 4);
        send_line(-3, 2, -1, 5, 24'hA5_5A3C, 4);
        send_line(2, 1030, 4, 1027, 24'h5A_A5C3, 3);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: begin
                        write_cfg(REG_LINE_STRIDE, 14'd0);
                        write_cfg(REG_BITS_PER_PIXEL, 14'd8);
                    end
                    2: begin
                        write_cfg(REG_LINE_STRIDE, 14'h3FFF);
                        write_cfg(REG_BITS_PER_PIXEL, 14'd32);
                    end
                    3: begin
                        write_cfg(REG_LINE_STRIDE, CFG_DATA_W'($urandom));
                        write_cfg(REG_BITS_PER_PIXEL, CFG_DATA_W'($urandom));
                    end
                    4: begin
                        write_cfg(REG_LINE_STRIDE, 14'd1024);
                        write_cfg(REG_BITS_PER_PIXEL, 14'd0);
                    end
                    default: begin
                        write_cfg(REG_LINE_STRIDE, 14'd4096);
                        write_cfg(REG_BITS_PER_PIXEL, 14'h3FFF);
                    end
                endcase
            end
            // One phase runs with no idling on either side.
            idle_pct = (phase == 2) ? 0 : 18;
            stall_pct = (phase == 2) ? 0 : 18;
            target = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < target) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    random_line();
                end else if (r < 90) begin
                    repeat ($urandom_range(4, 1))
                        send_step();
                end else begin
                    send_line(int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              int'($urandom_range(4095)) - 2048,
                              COLOR_W'($urandom), 0);
                    random_line();
                end
            end
        end

        drain();
        sb.mismatches += sb.pending_pixels.size();
        $display("Sent %0d beats over %0d register writes; checked %0d pixel beats,",
                 beats_sent, reg_writes, sb.pixels_checked);
        $display("%0d drawn (%0d visible) and %0d after the end of a line.",
                 sb.pixels_drawn, sb.pixels_visible, sb.finished_replies);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/dlpw_pkg.sv
rtl/dlpw_front.sv
rtl/dlpw_queue.sv
rtl/dlpw_back.sv
rtl/dda_line_pixel_walker.sv
sim/tb_dda_line_pixel_walker.sv
